// ----- hw/rtl/sn2d_pkg.sv -----
// sn2d_pkg: shared constants for the 2d simplex noise pipeline
`default_nettype none
package sn2d_pkg;

    // permutation table geometry
    localparam int TABLE_SIZE = 256;
    localparam int TABLE_AW   = $clog2(TABLE_SIZE);

    // input selector codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // gradient codes from the low two hash bits
    localparam logic [1:0] GRAD_NEG_X = 2'd0;
    localparam logic [1:0] GRAD_NEG_Y = 2'd1;
    localparam logic [1:0] GRAD_POS_X = 2'd2;
    localparam logic [1:0] GRAD_POS_Y = 2'd3;

    // skew (sqrt(3)-1)/2 and unskew (3-sqrt(3))/6 in q.32
    localparam logic [30:0] SKEW_F   = 31'd1572067139;
    localparam logic [29:0] UNSKEW_G = 30'd907633386;

    // corner offsets carried as 36-bit q.32 (true range is well inside +-1)
    localparam int OFS_W = 36;
    localparam logic [OFS_W-1:0] ONE_Q32  = 36'h1_0000_0000;
    localparam logic [33:0]      HALF_Q30 = 34'd536870912;
    localparam logic signed [39:0] ONE_Q30_S = 40'sd1073741824;

    // output scale
    localparam logic signed [39:0] SCALE_OUT = 40'sd70;

    // corner count per triangle
    localparam int NUM_CORNERS = 3;

endpackage
`default_nettype wire

// ----- hw/rtl/sn2d_ram.sv -----
// sn2d_ram: generic single-write, single-read ram with registered read
`default_nettype none
module sn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/simplex_noise_2d.sv -----
// simplex_noise_2d: pipelined 2d simplex noise with a loadable permutation table
// throughput: one beat per cycle while the skid stage is free, loads and samples mixed in any order
// the table is replicated in five rams, written in pipeline order so loads and
// samples take effect in the order they were accepted; a two-entry output
// register and skid stage keep the pipe moving while one result waits
// reset clears all valid bits; table contents are undefined until loaded
`default_nettype none
module simplex_noise_2d (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // x_coord[31:0], y_coord[63:32],
                                        // table_index[71:64], table_value[79:72]
    input  wire logic        s_tuser,   // func[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // noise[15:0]
    output logic             m_tuser    // out_of_range[0]
);

    import sn2d_pkg::*;

    logic adv;

    // stage 1: input capture
    logic               v1_reg, f1_reg;
    logic signed [31:0] x1_reg, y1_reg;
    logic [7:0]         idx1_reg, val1_reg;

    // stage 2: skew product
    logic               v2_reg, f2_reg;
    logic signed [63:0] prod2_reg;
    logic signed [31:0] x2_reg, y2_reg;
    logic [7:0]         idx2_reg, val2_reg;
    logic signed [32:0] sum_xy;
    logic signed [63:0] prod_next;

    // stage 3: cell coordinates
    logic               v3_reg, f3_reg;
    logic signed [17:0] i3_reg, j3_reg;
    logic [19:0]        xl3_reg, yl3_reg;
    logic [7:0]         idx3_reg, val3_reg;
    logic signed [47:0] skew_s;
    logic signed [49:0] xs_sum, ys_sum;

    // stage 4: unskew term
    logic               v4_reg, f4_reg;
    logic [OFS_W-1:0]   t4_reg;
    logic [7:0]         i4_reg, j4_reg;
    logic [19:0]        xl4_reg, yl4_reg;
    logic [7:0]         idx4_reg, val4_reg;
    logic signed [18:0] ij_sum;
    logic signed [49:0] t_full;

    // stage 5: first corner offset, first hash level
    logic               v5_reg, f5_reg;
    logic [OFS_W-1:0]   x0_reg, y0_reg;
    logic [7:0]         ii5_reg;
    logic [7:0]         idx5_reg, val5_reg;
    logic [7:0]         pj0, pj1;
    logic [7:0]         jj_inc;

    // stage 6: all corner offsets, gradients
    logic               v6_reg;
    logic [OFS_W-1:0]   ofx6_reg [NUM_CORNERS];
    logic [OFS_W-1:0]   ofy6_reg [NUM_CORNERS];
    logic               i1_sel;
    logic [7:0]         haddr [NUM_CORNERS];
    logic [7:0]         hval  [NUM_CORNERS];
    logic [OFS_W-1:0]   ofx_next [NUM_CORNERS];
    logic [OFS_W-1:0]   ofy_next [NUM_CORNERS];

    // stage 7: squares and selected gradient component
    logic               v7_reg;
    logic [31:0]        sqx7_reg [NUM_CORNERS];
    logic [31:0]        sqy7_reg [NUM_CORNERS];
    logic signed [31:0] g7_reg   [NUM_CORNERS];
    logic [31:0]        sqx_next [NUM_CORNERS];
    logic [31:0]        sqy_next [NUM_CORNERS];
    logic signed [31:0] g_next   [NUM_CORNERS];

    // stage 8: falloff base
    logic               v8_reg;
    logic [29:0]        t8_reg  [NUM_CORNERS];
    logic               neg8_reg [NUM_CORNERS];
    logic signed [31:0] g8_reg  [NUM_CORNERS];
    logic [29:0]        t_next  [NUM_CORNERS];
    logic               neg_next [NUM_CORNERS];

    // stage 9: t^2
    logic               v9_reg;
    logic [28:0]        tt9_reg  [NUM_CORNERS];
    logic               neg9_reg [NUM_CORNERS];
    logic signed [31:0] g9_reg   [NUM_CORNERS];
    logic [28:0]        tt_next  [NUM_CORNERS];

    // stage 10: t^4
    logic               v10_reg;
    logic [26:0]        t4q10_reg [NUM_CORNERS];
    logic               neg10_reg [NUM_CORNERS];
    logic signed [31:0] g10_reg   [NUM_CORNERS];
    logic [26:0]        t4q_next  [NUM_CORNERS];

    // stage 11: corner contributions
    logic               v11_reg;
    logic signed [29:0] c11_reg [NUM_CORNERS];
    logic signed [29:0] c_next  [NUM_CORNERS];

    // stage 12: scaled sum
    logic               v12_reg;
    logic signed [39:0] r12_reg;
    logic signed [39:0] r_next;

    // stage 13: rounded and saturated result
    logic               v13_reg;
    logic [15:0]        q13_reg;
    logic               oor13_reg;
    logic signed [24:0] q_full;
    logic [15:0]        q_next;
    logic               oor_next;

    // output register and skid
    logic               out_valid_reg, skid_valid_reg;
    logic [15:0]        out_q_reg, skid_q_reg;
    logic               out_oor_reg, skid_oor_reg;

    // pipe advances whenever the skid stage is free
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // ---------------- datapath logic ----------------

    // skew product (x+y)*F
    always_comb
    begin
        sum_xy    = 33'(x1_reg) + 33'(y1_reg);
        prod_next = 64'(sum_xy) * 64'($signed({1'b0, SKEW_F}));
    end

    // cell index floor(x + s)
    always_comb
    begin
        skew_s = prod2_reg[63:16];
        xs_sum = (50'(x2_reg) <<< 16) + 50'(skew_s);
        ys_sum = (50'(y2_reg) <<< 16) + 50'(skew_s);
    end

    // unskew term (i+j)*G
    always_comb
    begin
        ij_sum = 19'(i3_reg) + 19'(j3_reg);
        t_full = 50'(ij_sum) * 50'($signed({1'b0, UNSKEW_G}));
    end

    // level-one table reads from the stage-4 cell row
    assign jj_inc = j4_reg + 8'd1;

    sn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_j0 (
        .clk   (clk),
        .we    (adv && v4_reg && (f4_reg == FUNC_LOAD)),
        .waddr (idx4_reg),
        .wdata (val4_reg),
        .re    (adv),
        .raddr (j4_reg),
        .rdata (pj0)
    );

    sn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_j1 (
        .clk   (clk),
        .we    (adv && v4_reg && (f4_reg == FUNC_LOAD)),
        .waddr (idx4_reg),
        .wdata (val4_reg),
        .re    (adv),
        .raddr (jj_inc),
        .rdata (pj1)
    );

    // triangle choice, remaining offsets and level-two hash addresses
    always_comb
    begin
        i1_sel      = $signed(x0_reg) > $signed(y0_reg);
        ofx_next[0] = x0_reg;
        ofy_next[0] = y0_reg;
        ofx_next[1] = x0_reg - (i1_sel ? ONE_Q32 : '0) + OFS_W'(UNSKEW_G);
        ofy_next[1] = y0_reg - (i1_sel ? '0 : ONE_Q32) + OFS_W'(UNSKEW_G);
        ofx_next[2] = x0_reg - ONE_Q32 + (OFS_W'(UNSKEW_G) << 1);
        ofy_next[2] = y0_reg - ONE_Q32 + (OFS_W'(UNSKEW_G) << 1);
        haddr[0]    = ii5_reg + pj0;
        haddr[1]    = ii5_reg + 8'(i1_sel) + (i1_sel ? pj0 : pj1);
        haddr[2]    = ii5_reg + 8'd1 + pj1;
    end

    for (genvar c = 0; c < NUM_CORNERS; c++)
    begin : g_hash
        sn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_h (
            .clk   (clk),
            .we    (adv && v5_reg && (f5_reg == FUNC_LOAD)),
            .waddr (idx5_reg),
            .wdata (val5_reg),
            .re    (adv),
            .raddr (haddr[c]),
            .rdata (hval[c])
        );
    end

    // per-corner arithmetic
    always_comb
    begin
        logic signed [31:0] ax, ay;
        logic signed [63:0] px, py;
        logic signed [33:0] tt;
        logic [59:0]        p2;
        logic [57:0]        p4;
        logic signed [59:0] pc;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            // squares of offsets in q.30
            ax = 32'($signed(ofx6_reg[c]) >>> 2);
            ay = 32'($signed(ofy6_reg[c]) >>> 2);
            px = 64'(ax) * 64'(ax);
            py = 64'(ay) * 64'(ay);
            sqx_next[c] = px[61:30];
            sqy_next[c] = py[61:30];
            case (hval[c][1:0])
                GRAD_NEG_X: g_next[c] = -ax;
                GRAD_NEG_Y: g_next[c] = -ay;
                GRAD_POS_X: g_next[c] = ax;
                default:    g_next[c] = ay;
            endcase

            // falloff base 0.5 - r^2
            tt = $signed(HALF_Q30 - {2'b00, sqx7_reg[c]} - {2'b00, sqy7_reg[c]});
            neg_next[c] = tt[33];
            t_next[c]   = tt[29:0];

            // t^2 and t^4 in q.30
            p2 = 60'(t8_reg[c]) * 60'(t8_reg[c]);
            tt_next[c] = p2[58:30];
            p4 = 58'(tt9_reg[c]) * 58'(tt9_reg[c]);
            t4q_next[c] = p4[56:30];

            // t^4 times gradient component, floored to q.30, zero where the falloff base is negative
            pc = 60'($signed({1'b0, t4q10_reg[c]})) * 60'(g10_reg[c]);
            c_next[c] = neg10_reg[c] ? '0 : pc[59:30];
        end
    end

    // sum of corners scaled by 70
    always_comb
    begin
        logic signed [31:0] csum;
        csum   = 32'(c11_reg[0]) + 32'(c11_reg[1]) + 32'(c11_reg[2]);
        r_next = 40'(csum) * SCALE_OUT;
    end

    // round to q1.15, saturate and flag results beyond +-1
    always_comb
    begin
        q_full   = 25'((r12_reg + 40'sd16384) >>> 15);
        oor_next = (r12_reg < -ONE_Q30_S) || (r12_reg > ONE_Q30_S);
        if (q_full > 25'sd32767)
        begin
            q_next = 16'h7FFF;
        end
        else if (q_full < -25'sd32768)
        begin
            q_next = 16'h8000;
        end
        else
        begin
            q_next = q_full[15:0];
        end
    end

    // ---------------- pipeline registers ----------------

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            // loads end here, only samples go on
            v6_reg  <= v5_reg && (f5_reg == FUNC_SAMPLE);
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg   <= s_tuser;
            x1_reg   <= $signed(s_tdata[31:0]);
            y1_reg   <= $signed(s_tdata[63:32]);
            idx1_reg <= s_tdata[71:64];
            val1_reg <= s_tdata[79:72];

            f2_reg    <= f1_reg;
            prod2_reg <= prod_next;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;

            f3_reg   <= f2_reg;
            i3_reg   <= xs_sum[49:32];
            j3_reg   <= ys_sum[49:32];
            xl3_reg  <= x2_reg[19:0];
            yl3_reg  <= y2_reg[19:0];
            idx3_reg <= idx2_reg;
            val3_reg <= val2_reg;

            f4_reg   <= f3_reg;
            t4_reg   <= t_full[OFS_W-1:0];
            i4_reg   <= i3_reg[7:0];
            j4_reg   <= j3_reg[7:0];
            xl4_reg  <= xl3_reg;
            yl4_reg  <= yl3_reg;
            idx4_reg <= idx3_reg;
            val4_reg <= val3_reg;

            f5_reg   <= f4_reg;
            x0_reg   <= {xl4_reg, 16'h0} - {i4_reg[3:0], 32'h0} + t4_reg;
            y0_reg   <= {yl4_reg, 16'h0} - {j4_reg[3:0], 32'h0} + t4_reg;
            ii5_reg  <= i4_reg;
            idx5_reg <= idx4_reg;
            val5_reg <= val4_reg;

            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                ofx6_reg[c]  <= ofx_next[c];
                ofy6_reg[c]  <= ofy_next[c];
                sqx7_reg[c]  <= sqx_next[c];
                sqy7_reg[c]  <= sqy_next[c];
                g7_reg[c]    <= g_next[c];
                t8_reg[c]    <= t_next[c];
                neg8_reg[c]  <= neg_next[c];
                g8_reg[c]    <= g7_reg[c];
                tt9_reg[c]   <= tt_next[c];
                neg9_reg[c]  <= neg8_reg[c];
                g9_reg[c]    <= g8_reg[c];
                t4q10_reg[c] <= t4q_next[c];
                neg10_reg[c] <= neg9_reg[c];
                g10_reg[c]   <= g9_reg[c];
                c11_reg[c]   <= c_next[c];
            end

            r12_reg   <= r_next;
            q13_reg   <= q_next;
            oor13_reg <= oor_next;
        end
    end

    // ---------------- output register and skid ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= v13_reg;
            end
        end
        else if (v13_reg && adv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // skid only takes a beat while it is empty
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_q_reg   <= skid_valid_reg ? skid_q_reg : q13_reg;
            out_oor_reg <= skid_valid_reg ? skid_oor_reg : oor13_reg;
        end
        else if (v13_reg && adv)
        begin
            skid_q_reg   <= q13_reg;
            skid_oor_reg <= oor13_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_q_reg;
    assign m_tuser  = out_oor_reg;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: streams table loads and noise samples into simplex_noise_2d and checks every result
`default_nettype none
module testbench;
    import sn2d_pkg::*;

    // one input beat as the testbench sees it
    typedef struct packed {
        logic        func;
        logic [31:0] x_coord;
        logic [31:0] y_coord;
        logic [7:0]  table_index;
        logic [7:0]  table_value;
    } beat_t;

    // one expected result
    typedef struct packed {
        logic [15:0] noise;
        logic        out_of_range;
    } noise_t;

    localparam int  NUM_RANDOM  = 180;
    localparam int  HOLD_AT     = 40;
    localparam int  PAUSE_AT    = 100;
    localparam int  QUIET_TAIL  = 60;
    localparam int  LONG_HOLD   = 200;
    localparam int  DRAIN_WAIT  = 20;
    localparam int  CYCLE_LIMIT = 200000;
    localparam longint ONE_Q32_L = 64'sd4294967296;
    localparam longint ONE_Q30_L = 64'sd1073741824;
    localparam longint HALF_Q30_L = 64'sd536870912;
    localparam longint SKEW_L    = 64'sd1572067139;
    localparam longint UNSKEW_L  = 64'sd907633386;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    logic [7:0]  perm_copy [TABLE_SIZE];
    noise_t      noise_q [$];
    int          errors = 0;
    int          cycles = 0;
    int          n_samples = 0;
    int          n_loads = 0;
    int          n_clipped = 0;
    int          n_checked = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    simplex_noise_2d u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", noise_q.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] perm_at(longint idx);
        return perm_copy[idx[7:0]];
    endfunction

    // contribution of one corner in q.30 from q.32 offsets
    function automatic longint corner_term(longint dx, longint dy, logic [1:0] grad);
        longint ax, ay, t, comp;
        ax = dx >>> 2;
        ay = dy >>> 2;
        t = HALF_Q30_L - ((ax * ax) >>> 30) - ((ay * ay) >>> 30);
        if (t < 0)
            return 0;
        t = (t * t) >>> 30;
        t = (t * t) >>> 30;
        case (grad)
            GRAD_NEG_X: comp = -ax;
            GRAD_NEG_Y: comp = -ay;
            GRAD_POS_X: comp = ax;
            default:    comp = ay;
        endcase
        return (t * comp) >>> 30;
    endfunction

    // noise value and range flag for one point
    function automatic noise_t noise_at(logic [31:0] xr, logic [31:0] yr);
        longint x, y, xq, yq, s, i, j, t, x0, y0, x1, y1, x2, y2, sum, r, q;
        longint ii, jj, i1, j1;
        logic [1:0] g0, g1, g2;
        noise_t res;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        xq = x * 65536;
        yq = y * 65536;
        s = ((x + y) * SKEW_L) >>> 16;
        i = (xq + s) >>> 32;
        j = (yq + s) >>> 32;
        t = (i + j) * UNSKEW_L;
        x0 = xq - (i * ONE_Q32_L - t);
        y0 = yq - (j * ONE_Q32_L - t);
        if (x0 > y0)
        begin
            i1 = 1;
            j1 = 0;
        end
        else
        begin
            i1 = 0;
            j1 = 1;
        end
        x1 = x0 - i1 * ONE_Q32_L + UNSKEW_L;
        y1 = y0 - j1 * ONE_Q32_L + UNSKEW_L;
        x2 = x0 - ONE_Q32_L + 2 * UNSKEW_L;
        y2 = y0 - ONE_Q32_L + 2 * UNSKEW_L;
        ii = i & 255;
        jj = j & 255;
        g0 = 2'(perm_at(ii + perm_at(jj)));
        g1 = 2'(perm_at(ii + i1 + perm_at(jj + j1)));
        g2 = 2'(perm_at(ii + 1 + perm_at(jj + 1)));
        sum = corner_term(x0, y0, g0) + corner_term(x1, y1, g1) + corner_term(x2, y2, g2);
        r = 70 * sum;
        q = (r + 16384) >>> 15;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        res.noise = q[15:0];
        res.out_of_range = (r < -ONE_Q30_L || r > ONE_Q30_L);
        return res;
    endfunction

    // offer one beat until taken; table update and prediction happen at acceptance
    task automatic send_beat(beat_t b);
        bit taken;
        s_tvalid <= 1'b1;
        s_tuser  <= b.func;
        s_tdata  <= {b.table_value, b.table_index, b.y_coord, b.x_coord};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            if (taken)
            begin
                if (b.func == FUNC_LOAD)
                begin
                    perm_copy[b.table_index] = b.table_value;
                    n_loads++;
                end
                else
                begin
                    noise_q.insert(noise_q.size(), noise_at(b.x_coord, b.y_coord));
                    n_samples++;
                end
            end
            @(posedge clk);
        end
        // random gap after the beat
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    function automatic beat_t load_beat(logic [7:0] idx, logic [7:0] val);
        beat_t b;
        b = '0;
        b.func = FUNC_LOAD;
        b.table_index = idx;
        b.table_value = val;
        return b;
    endfunction

    function automatic beat_t sample_beat(logic [31:0] x, logic [31:0] y);
        beat_t b;
        b.func = FUNC_SAMPLE;
        b.x_coord = x;
        b.y_coord = y;
        b.table_index = 8'($urandom);
        b.table_value = 8'($urandom);
        return b;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) < 7)
            return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        return $urandom;
    endfunction

    // directed beats: loads at the table ends, coordinate extremes, index wrap
    beat_t directed_tbl [16] = '{
        '{FUNC_LOAD,   32'h0000_0000, 32'h0000_0000, 8'h00, 8'hFF},
        '{FUNC_LOAD,   32'h0000_0000, 32'h0000_0000, 8'hFF, 8'h00},
        '{FUNC_SAMPLE, 32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF},
        '{FUNC_SAMPLE, 32'h8000_0000, 32'h8000_0000, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 8'hAA, 8'h55},
        '{FUNC_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 8'h55, 8'hAA},
        '{FUNC_SAMPLE, 32'h0000_0001, 32'h0000_0000, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'h0000_0000, 32'h0000_0001, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'h0001_0000, 32'h0001_0000, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'h0000_8000, 32'h0000_4000, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'h00FF_8000, 32'h00FF_8000, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'h00FF_C000, 32'h00FE_4000, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'hFFFF_0000, 32'h0000_C000, 8'h00, 8'h00},
        '{FUNC_SAMPLE, 32'h0000_5555, 32'hFFFF_AAAB, 8'h00, 8'h00}
    };

    // receiver: random stalls, one long hold on request, none at the end
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result check, sampled mid-cycle for the beat taken at the next edge
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (noise_q.size() == 0)
            begin
                $error("result beat with nothing expected: noise %h", m_tdata);
                errors++;
            end
            else
            begin
                noise_t e;
                e = noise_q.pop_front();
                n_checked++;
                if (e.out_of_range)
                    n_clipped++;
                if (m_tdata !== e.noise)
                begin
                    $error("noise expected %h got %h", e.noise, m_tdata);
                    errors++;
                end
                if (m_tuser !== e.out_of_range)
                begin
                    $error("out_of_range expected %b got %b", e.out_of_range, m_tuser);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [7:0] shuffle [TABLE_SIZE];
        logic [7:0] tmp;
        int k, m;
        beat_t b;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full permutation load before any sample
        for (k = 0; k < TABLE_SIZE; k++)
            shuffle[k] = k[7:0];
        for (k = TABLE_SIZE - 1; k > 0; k--)
        begin
            m = $urandom_range(0, k);
            tmp = shuffle[k];
            shuffle[k] = shuffle[m];
            shuffle[m] = tmp;
        end
        for (k = 0; k < TABLE_SIZE; k++)
            send_beat(load_beat(k[7:0], shuffle[k]));

        foreach (directed_tbl[k])
            send_beat(directed_tbl[k]);

        for (k = 0; k < NUM_RANDOM; k++)
        begin
            if (k == HOLD_AT)
                hold_req = 1'b1;
            // pause until the pipe is empty
            if (k == PAUSE_AT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (noise_q.size() != 0)
                    @(posedge clk);
            end
            if (k == NUM_RANDOM - QUIET_TAIL)
                quiet = 1'b1;
            if ($urandom_range(0, 99) < 15)
                b = load_beat(8'($urandom), 8'($urandom));
            else
                b = sample_beat(rand_coord(), rand_coord());
            send_beat(b);
        end
        s_tvalid <= 1'b0;

        while (noise_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d table loads and %0d noise samples, %0d results checked",
                 n_loads, n_samples, n_checked);
        $display("%0d results out of range, one long output hold and one drain pause",
                 n_clipped);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
